// File: hdl/record_lock_table_core_defines.svh
// assertion macros shared by the lock table rtl
`ifndef RECORD_LOCK_TABLE_CORE_DEFINES_SVH
`define RECORD_LOCK_TABLE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rlt_pkg.sv
package rlt_pkg;

  localparam int LOCK_SLOTS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int FILE_W   = 8;
  localparam int INODE_W  = 12;
  localparam int OFFSET_W = 32;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_LOCK   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [FILE_W-1:0]   file_id;
    logic [INODE_W-1:0]  inode_id;
    logic [OFFSET_W-1:0] start;
    logic [SIZE_W-1:0]   length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic file_eq;
    logic inode_eq;
    logic overlap;
  } hit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_t;

endpackage

// File: hdl/record_lock_table_core.sv
// sequence: once start is taken, the FSM steps through SCAN, LAST and COMMIT, and
//   out_valid is registered out of COMMIT; one request at a time, taken only while busy is
//   low; the slot memory read port scans one slot per cycle, then the compare and commit follow
// reset: synchronous on rst_n low; all slots free, no result pending, busy low
// results come as a one-cycle strobe on out_valid; the receiver cannot stall
`include "record_lock_table_core_defines.svh"

module record_lock_table_core #(
  parameter int LOCK_SLOTS = rlt_pkg::LOCK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rlt_pkg::OP_W-1:0]      in_opcode,
  input  logic [rlt_pkg::FILE_W-1:0]    in_file_id,
  input  logic [rlt_pkg::INODE_W-1:0]   in_inode_id,
  input  logic [rlt_pkg::OFFSET_W-1:0]  in_region_offset,
  input  logic [rlt_pkg::SIZE_W-1:0]    in_region_size,
  output logic                          out_valid,
  output logic [rlt_pkg::STATUS_W-1:0]  out_status
);

  localparam int SLOT_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(LOCK_SLOTS + 1);

  rlt_pkg::state_t state_r, state_nxt;

  logic [rlt_pkg::OP_W-1:0]     op_r;
  rlt_pkg::entry_t              req_r;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         pv_r;
  logic [SLOT_W-1:0]            kd_r;
  logic                         conflict_r, conflict_nxt;
  logic                         free_ok_r, free_ok_nxt;
  logic [SLOT_W-1:0]            free_r, free_nxt;
  logic [LOCK_SLOTS-1:0]        used_r, used_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rlt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                         accept;
  logic                         ram_re, ram_we;
  rlt_pkg::entry_t              ram_rdata;
  logic [rlt_pkg::ENTRY_W-1:0]  ram_rbits;
  rlt_pkg::hit_t                hit;
  logic                         used_k;

  assign busy       = (state_r != rlt_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign ram_rdata  = rlt_pkg::entry_t'(ram_rbits);

  // writes happen only in commit, after the scan is over, so no read can
  // see a half-written entry and no forwarding path is needed
  rlt_ram #(
    .WIDTH(rlt_pkg::ENTRY_W),
    .DEPTH(LOCK_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_r),
    .wdata(req_r),
    .re   (ram_re),
    .raddr(cnt_r[SLOT_W-1:0]),
    .rdata(ram_rbits)
  );

  rlt_match u_match (
    .op (op_r),
    .req(req_r),
    .ent(ram_rdata),
    .hit(hit)
  );

  assign used_k = used_r[kd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlt_pkg::ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= (state_r == rlt_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r           <= in_opcode;
      req_r.file_id  <= in_file_id;
      req_r.inode_id <= in_inode_id;
      req_r.start    <= in_region_offset;
      req_r.length   <= in_region_size;
    end
    kd_r         <= cnt_r[SLOT_W-1:0];
    cnt_r        <= cnt_nxt;
    conflict_r   <= conflict_nxt;
    free_ok_r    <= free_ok_nxt;
    free_r       <= free_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    conflict_nxt   = conflict_r;
    free_ok_nxt    = free_ok_r;
    free_nxt       = free_r;
    used_nxt       = used_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    ram_re         = 1'b0;
    ram_we         = 1'b0;

    // compare stage: slot kd_r's data arrived from the memory this cycle
    if (pv_r) begin
      case (op_r)
        rlt_pkg::OP_LOCK: begin
          if (used_k && hit.inode_eq && hit.overlap) begin
            conflict_nxt = 1'b1;
          end
          // ascending scan, so the last free slot seen is the highest
          if (!used_k) begin
            free_ok_nxt = 1'b1;
            free_nxt    = kd_r;
          end
        end
        rlt_pkg::OP_UNLOCK: begin
          if (used_k && hit.file_eq && hit.overlap) begin
            used_nxt[kd_r] = 1'b0;
          end
        end
        rlt_pkg::OP_CLOSE: begin
          if (used_k && hit.file_eq) begin
            used_nxt[kd_r] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      rlt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt    = rlt_pkg::ST_SCAN;
          cnt_nxt      = '0;
          conflict_nxt = 1'b0;
          free_ok_nxt  = 1'b0;
        end
      end
      rlt_pkg::ST_SCAN: begin
        ram_re  = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(LOCK_SLOTS - 1)) begin
          state_nxt = rlt_pkg::ST_LAST;
        end
      end
      rlt_pkg::ST_LAST: begin
        state_nxt = rlt_pkg::ST_COMMIT;
      end
      rlt_pkg::ST_COMMIT: begin
        state_nxt      = rlt_pkg::ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = rlt_pkg::STATUS_DONE;
        if (op_r == rlt_pkg::OP_LOCK) begin
          if (conflict_r) begin
            out_status_nxt = rlt_pkg::STATUS_BUSY;
          end else if (!free_ok_r) begin
            out_status_nxt = rlt_pkg::STATUS_FULL;
          end else begin
            ram_we           = 1'b1;
            used_nxt[free_r] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = rlt_pkg::ST_IDLE;
      end
    endcase
  end

  `RLT_ASSERT_NEXT(a_commit_gives_result, state_r == rlt_pkg::ST_COMMIT, out_valid_r, "commit did not produce a result")
  `RLT_ASSERT_NOW(a_result_only_idle, out_valid_r, state_r == rlt_pkg::ST_IDLE, "result strobe outside idle")
  `RLT_ASSERT_NOW(a_write_only_clean_lock, ram_we, (op_r == rlt_pkg::OP_LOCK) && !conflict_r && free_ok_r && !used_r[free_r], "slot write without a clean lock into a free slot")
  `RLT_ASSERT_NEXT(a_write_marks_used, ram_we, used_r[free_r], "written slot not marked used")
  `RLT_ASSERT_NOW(a_full_means_no_free, out_valid_r && (out_status_r == rlt_pkg::STATUS_FULL), !free_ok_r, "table full reported with a free slot")

endmodule

// File: hdl/rlt_ram.sv
module rlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/rlt_match.sv
module rlt_match (
  input  logic [rlt_pkg::OP_W-1:0] op,
  input  rlt_pkg::entry_t          req,
  input  rlt_pkg::entry_t          ent,
  output rlt_pkg::hit_t            hit
);

  logic [rlt_pkg::SIZE_W-1:0]   span;
  logic [rlt_pkg::OFFSET_W:0]   req_end;
  logic [rlt_pkg::OFFSET_W:0]   ent_end;

  // unlock probes a single byte
  assign span = (op == rlt_pkg::OP_LOCK) ? req.length : rlt_pkg::SIZE_W'(1);

  // both ends one bit wider so they never wrap
  assign req_end = {1'b0, req.start} + {{(rlt_pkg::OFFSET_W + 1 - rlt_pkg::SIZE_W){1'b0}}, span};
  assign ent_end = {1'b0, ent.start} +
                   {{(rlt_pkg::OFFSET_W + 1 - rlt_pkg::SIZE_W){1'b0}}, ent.length};

  assign hit.file_eq  = (ent.file_id == req.file_id);
  assign hit.inode_eq = (ent.inode_id == req.inode_id);
  assign hit.overlap  = (req_end > {1'b0, ent.start}) && (ent_end > {1'b0, req.start});

endmodule
